// ===== hw/rtl/sbsi_pkg.sv =====
// shared constants, register map and divider step for the segment box slab test
package sbsi_pkg;

    localparam int COORD_W = 32;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int REM_W   = DIFF_W + 1;
    localparam int ADDR_W  = 5;
    localparam int DATA_W  = 32;

    // register indexes on the config port
    localparam logic [2:0] REG_BOX_MIN_X = 3'd0;
    localparam logic [2:0] REG_BOX_MIN_Y = 3'd1;
    localparam logic [2:0] REG_BOX_MIN_Z = 3'd2;
    localparam logic [2:0] REG_BOX_MAX_X = 3'd3;
    localparam logic [2:0] REG_BOX_MAX_Y = 3'd4;
    localparam logic [2:0] REG_BOX_MAX_Z = 3'd5;

    localparam logic [COORD_W-1:0] BOX_MIN_RESET = 32'hFFFF_8000;
    localparam logic [COORD_W-1:0] BOX_MAX_RESET = 32'h0000_8000;

    // one restoring division step: {quotient bit, new remainder}
    function automatic logic [REM_W:0] div_step(input logic [REM_W-1:0] r,
                                                input logic [DIFF_W-1:0] den);
        logic [REM_W-1:0] dd;
        dd = {1'b0, den};
        if (r >= dd)
            return {1'b1, r - dd};
        else
            return {1'b0, r};
    endfunction

    // magnitude of a signed difference
    function automatic logic [DIFF_W-1:0] mag(input logic [DIFF_W-1:0] x);
        return x[DIFF_W-1] ? (~x + DIFF_W'(1)) : x;
    endfunction

endpackage

// ===== hw/rtl/sbsi_if.sv =====
// valid/ready channels for segments in and intersection results out
interface sbsi_seg_if;
    logic        valid;
    logic        ready;
    logic [31:0] start_x;
    logic [31:0] start_y;
    logic [31:0] start_z;
    logic [31:0] end_x;
    logic [31:0] end_y;
    logic [31:0] end_z;

    modport source (output valid, start_x, start_y, start_z, end_x, end_y, end_z,
                    input ready);
    modport sink   (input valid, start_x, start_y, start_z, end_x, end_y, end_z,
                    output ready);
endinterface

interface sbsi_res_if #(parameter int FW = 17);
    logic          valid;
    logic          ready;
    logic          hit;
    logic [FW-1:0] entry_fraction;
    logic [31:0]   hit_x;
    logic [31:0]   hit_y;
    logic [31:0]   hit_z;

    modport source (output valid, hit, entry_fraction, hit_x, hit_y, hit_z, input ready);
    modport sink   (input valid, hit, entry_fraction, hit_x, hit_y, hit_z, output ready);
endinterface

// ===== hw/rtl/segment_box_slab_intersect_unit.sv =====
// top level of the segment against axis-aligned box slab test
// Tests each incoming segment against the box held in six config registers and
// returns one result per segment, in order: hit flag, entry fraction (unsigned
// Q1.FRACTION_BITS) and the hit point (signed Q16.16), all zero on a miss.
// Three axis lanes work side by side; each lane divides out its entry and exit
// fractions with two restoring dividers pipelined one quotient bit per stage, so
// a new segment can be taken every cycle while the output is not stalled. The
// pipeline has one setup stage, FRACTION_BITS + 1 divider stages, an interval
// merge stage, a multiply stage and the output register. Every stage has its
// own valid bit, so bubbles collapse and input keeps flowing while a result
// waits for transfer, until the pipeline is full. The user must write the box
// registers only while no segment is in flight; the block does not enforce it.
module segment_box_slab_intersect_unit #(
    parameter int FRACTION_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    sbsi_seg_if.sink                      seg_in,
    sbsi_res_if.source                    res_out,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [sbsi_pkg::ADDR_W-1:0]   paddr,
    input  logic [sbsi_pkg::DATA_W-1:0]   pwdata,
    output logic [sbsi_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);
    localparam int FW    = FRACTION_BITS + 1;
    localparam int DEPTH = FRACTION_BITS + 5;
    localparam int CW    = sbsi_pkg::COORD_W;
    localparam int DW    = sbsi_pkg::DIFF_W;

    // config registers
    logic [2:0][CW-1:0] box_min_reg, box_max_reg;
    logic [2:0]         reg_idx;
    logic               wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            box_min_reg <= {3{sbsi_pkg::BOX_MIN_RESET}};
            box_max_reg <= {3{sbsi_pkg::BOX_MAX_RESET}};
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                sbsi_pkg::REG_BOX_MIN_X: box_min_reg[0] <= pwdata;
                sbsi_pkg::REG_BOX_MIN_Y: box_min_reg[1] <= pwdata;
                sbsi_pkg::REG_BOX_MIN_Z: box_min_reg[2] <= pwdata;
                sbsi_pkg::REG_BOX_MAX_X: box_max_reg[0] <= pwdata;
                sbsi_pkg::REG_BOX_MAX_Y: box_max_reg[1] <= pwdata;
                sbsi_pkg::REG_BOX_MAX_Z: box_max_reg[2] <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            sbsi_pkg::REG_BOX_MIN_X: prdata = box_min_reg[0];
            sbsi_pkg::REG_BOX_MIN_Y: prdata = box_min_reg[1];
            sbsi_pkg::REG_BOX_MIN_Z: prdata = box_min_reg[2];
            sbsi_pkg::REG_BOX_MAX_X: prdata = box_max_reg[0];
            sbsi_pkg::REG_BOX_MAX_Y: prdata = box_max_reg[1];
            sbsi_pkg::REG_BOX_MAX_Z: prdata = box_max_reg[2];
            default:                 prdata = '0;
        endcase
    end

    // per-stage valid bits; a stage loads when it is empty or its successor loads
    logic [DEPTH-1:0] vld_reg;
    logic [DEPTH:0]   adv;

    assign adv[DEPTH] = res_out.ready;
    for (genvar k = 0; k < DEPTH; k++)
    begin : g_adv
        assign adv[k] = !vld_reg[k] || adv[k+1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            for (int k = 0; k < DEPTH; k++)
            begin
                if (adv[k])
                begin
                    vld_reg[k] <= (k == 0) ? seg_in.valid : vld_reg[k-1];
                end
            end
        end
    end

    assign seg_in.ready  = adv[0];
    assign res_out.valid = vld_reg[DEPTH-1];

    // axis lanes
    logic [2:0][CW-1:0] s_in, e_in, s_lane;
    logic [2:0][DW-1:0] d_lane;
    logic [2:0][FW-1:0] st_lane, et_lane;
    logic [2:0]         rej_lane;

    assign s_in = {seg_in.start_z, seg_in.start_y, seg_in.start_x};
    assign e_in = {seg_in.end_z, seg_in.end_y, seg_in.end_x};

    for (genvar a = 0; a < 3; a++)
    begin : g_lane
        sbsi_lane #(.FRACTION_BITS(FRACTION_BITS)) u_lane (
            .clk    (clk),
            .en     (adv[FRACTION_BITS+1:0]),
            .s_in   (s_in[a]),
            .e_in   (e_in[a]),
            .lo     (box_min_reg[a]),
            .hi     (box_max_reg[a]),
            .reject (rej_lane[a]),
            .st     (st_lane[a]),
            .et     (et_lane[a]),
            .s_out  (s_lane[a]),
            .d_out  (d_lane[a])
        );
    end

    // merge lanes and interpolate
    logic [2:0][CW-1:0] hit_pt;

    sbsi_merge #(.FRACTION_BITS(FRACTION_BITS)) u_merge (
        .clk            (clk),
        .en             (adv[DEPTH-1:DEPTH-3]),
        .reject         (rej_lane),
        .st             (st_lane),
        .et             (et_lane),
        .s              (s_lane),
        .d              (d_lane),
        .hit            (res_out.hit),
        .entry_fraction (res_out.entry_fraction),
        .hit_pt         (hit_pt)
    );

    assign res_out.hit_x = hit_pt[0];
    assign res_out.hit_y = hit_pt[1];
    assign res_out.hit_z = hit_pt[2];

    // a miss carries no fraction and no point
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res_out.valid && !res_out.hit) |->
        (res_out.entry_fraction == '0 && res_out.hit_x == '0 &&
         res_out.hit_y == '0 && res_out.hit_z == '0))
        else $error("miss result with nonzero payload");

    // entry fraction never exceeds one
    a_frac_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_out.valid |-> (res_out.entry_fraction <= {1'b1, {FRACTION_BITS{1'b0}}}))
        else $error("entry fraction above one");

    // full pipeline with stalled output must refuse input
    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (&vld_reg && !res_out.ready) |-> !seg_in.ready)
        else $error("input taken while pipeline full");

    // an item leaving stage zero shows up in stage one
    a_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg[0] && adv[1]) |=> vld_reg[1])
        else $error("item lost between stages");

endmodule

// ===== hw/rtl/sbsi_lane.sv =====
// one axis lane: slab classification and two pipelined restoring dividers
module sbsi_lane #(
    parameter int FRACTION_BITS = 16
) (
    input  logic                            clk,
    input  logic [FRACTION_BITS+1:0]        en,
    input  logic [sbsi_pkg::COORD_W-1:0]    s_in,
    input  logic [sbsi_pkg::COORD_W-1:0]    e_in,
    input  logic [sbsi_pkg::COORD_W-1:0]    lo,
    input  logic [sbsi_pkg::COORD_W-1:0]    hi,
    output logic                            reject,
    output logic [FRACTION_BITS:0]          st,
    output logic [FRACTION_BITS:0]          et,
    output logic [sbsi_pkg::COORD_W-1:0]    s_out,
    output logic [sbsi_pkg::DIFF_W-1:0]     d_out
);
    localparam int FW = FRACTION_BITS + 1;
    localparam int CW = sbsi_pkg::COORD_W;
    localparam int DW = sbsi_pkg::DIFF_W;
    localparam int RW = sbsi_pkg::REM_W;

    logic          rising;
    logic          rej_c, stn_c, etn_c;
    logic [DW-1:0] d_c, nlo_c, nhi_c;

    always_comb
    begin
        d_c    = {e_in[CW-1], e_in} - {s_in[CW-1], s_in};
        nlo_c  = {lo[CW-1], lo} - {s_in[CW-1], s_in};
        nhi_c  = {hi[CW-1], hi} - {s_in[CW-1], s_in};
        rising = $signed(s_in) < $signed(e_in);
        if (rising)
        begin
            rej_c = ($signed(s_in) > $signed(hi)) || ($signed(e_in) < $signed(lo));
            stn_c = $signed(s_in) < $signed(lo);
            etn_c = $signed(e_in) > $signed(hi);
        end
        else
        begin
            rej_c = ($signed(e_in) > $signed(hi)) || ($signed(s_in) < $signed(lo));
            stn_c = $signed(s_in) > $signed(hi);
            etn_c = $signed(e_in) < $signed(lo);
        end
    end

    // prep stage
    logic [DW-1:0] stnum_reg, etnum_reg, den_reg, d0_reg;
    logic [CW-1:0] s0_reg;
    logic          rej0_reg, stn0_reg, etn0_reg;

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            stnum_reg <= stn_c ? sbsi_pkg::mag(rising ? nlo_c : nhi_c) : '0;
            etnum_reg <= etn_c ? sbsi_pkg::mag(rising ? nhi_c : nlo_c) : '0;
            den_reg   <= sbsi_pkg::mag(d_c);
            d0_reg    <= d_c;
            s0_reg    <= s_in;
            rej0_reg  <= rej_c;
            stn0_reg  <= stn_c;
            etn0_reg  <= etn_c;
        end
    end

    // divider stages, one quotient bit each, msb first
    logic [RW-1:0] sr_reg [FW];
    logic [RW-1:0] er_reg [FW];
    logic [FW-1:0] sq_reg [FW];
    logic [FW-1:0] eq_reg [FW];
    logic [DW-1:0] den_p_reg [FW];
    logic [DW-1:0] d_p_reg [FW];
    logic [CW-1:0] s_p_reg [FW];
    logic          rej_p_reg [FW];
    logic          stn_p_reg [FW];
    logic          etn_p_reg [FW];

    for (genvar j = 0; j < FW; j++)
    begin : g_div
        logic [RW-1:0] sr_in, er_in;
        logic [FW-1:0] sq_in, eq_in;
        logic [DW-1:0] den_in, d_in;
        logic [CW-1:0] s_in_p;
        logic          rej_in, stn_in, etn_in;
        logic [RW:0]   sstep, estep;

        if (j == 0)
        begin : g_first
            assign sr_in  = {1'b0, stnum_reg};
            assign er_in  = {1'b0, etnum_reg};
            assign sq_in  = '0;
            assign eq_in  = '0;
            assign den_in = den_reg;
            assign d_in   = d0_reg;
            assign s_in_p = s0_reg;
            assign rej_in = rej0_reg;
            assign stn_in = stn0_reg;
            assign etn_in = etn0_reg;
        end
        else
        begin : g_next
            assign sr_in  = {sr_reg[j-1][RW-2:0], 1'b0};
            assign er_in  = {er_reg[j-1][RW-2:0], 1'b0};
            assign sq_in  = sq_reg[j-1];
            assign eq_in  = eq_reg[j-1];
            assign den_in = den_p_reg[j-1];
            assign d_in   = d_p_reg[j-1];
            assign s_in_p = s_p_reg[j-1];
            assign rej_in = rej_p_reg[j-1];
            assign stn_in = stn_p_reg[j-1];
            assign etn_in = etn_p_reg[j-1];
        end

        assign sstep = sbsi_pkg::div_step(sr_in, den_in);
        assign estep = sbsi_pkg::div_step(er_in, den_in);

        always_ff @(posedge clk)
        begin
            if (en[j+1])
            begin
                sr_reg[j]    <= sstep[RW-1:0];
                er_reg[j]    <= estep[RW-1:0];
                sq_reg[j]    <= {sq_in[FW-2:0], sstep[RW]};
                eq_reg[j]    <= {eq_in[FW-2:0], estep[RW]};
                den_p_reg[j] <= den_in;
                d_p_reg[j]   <= d_in;
                s_p_reg[j]   <= s_in_p;
                rej_p_reg[j] <= rej_in;
                stn_p_reg[j] <= stn_in;
                etn_p_reg[j] <= etn_in;
            end
        end
    end

    assign reject = rej_p_reg[FW-1];
    assign st     = stn_p_reg[FW-1] ? sq_reg[FW-1] : '0;
    assign et     = etn_p_reg[FW-1] ? eq_reg[FW-1] : {1'b1, {FRACTION_BITS{1'b0}}};
    assign s_out  = s_p_reg[FW-1];
    assign d_out  = d_p_reg[FW-1];

endmodule

// ===== hw/rtl/sbsi_merge.sv =====
// merges lane intervals, then interpolates the hit point
module sbsi_merge #(
    parameter int FRACTION_BITS = 16
) (
    input  logic                                  clk,
    input  logic [2:0]                            en,
    input  logic [2:0]                            reject,
    input  logic [2:0][FRACTION_BITS:0]           st,
    input  logic [2:0][FRACTION_BITS:0]           et,
    input  logic [2:0][sbsi_pkg::COORD_W-1:0]     s,
    input  logic [2:0][sbsi_pkg::DIFF_W-1:0]      d,
    output logic                                  hit,
    output logic [FRACTION_BITS:0]                entry_fraction,
    output logic [2:0][sbsi_pkg::COORD_W-1:0]     hit_pt
);
    localparam int FW = FRACTION_BITS + 1;
    localparam int CW = sbsi_pkg::COORD_W;
    localparam int DW = sbsi_pkg::DIFF_W;
    localparam int PW = DW + FW + 1;

    logic [FW-1:0] enter_c, leave_c, m01, n01;

    always_comb
    begin
        m01     = (st[1] > st[0]) ? st[1] : st[0];
        enter_c = (st[2] > m01) ? st[2] : m01;
        n01     = (et[1] < et[0]) ? et[1] : et[0];
        leave_c = (et[2] < n01) ? et[2] : n01;
    end

    // interval stage
    logic                  hit_a_reg;
    logic [FW-1:0]         enter_a_reg;
    logic [2:0][CW-1:0]    s_a_reg;
    logic [2:0][DW-1:0]    d_a_reg;

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            hit_a_reg   <= ~|reject && (leave_c >= enter_c);
            enter_a_reg <= enter_c;
            s_a_reg     <= s;
            d_a_reg     <= d;
        end
    end

    // product stage
    logic                  hit_b_reg;
    logic [FW-1:0]         enter_b_reg;
    logic [2:0][CW-1:0]    s_b_reg;
    logic [2:0][PW-1:0]    p_b_reg;

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            hit_b_reg   <= hit_a_reg;
            enter_b_reg <= enter_a_reg;
            s_b_reg     <= s_a_reg;
            for (int i = 0; i < 3; i++)
            begin
                p_b_reg[i] <= PW'($signed(d_a_reg[i]) * $signed({1'b0, enter_a_reg}));
            end
        end
    end

    // output stage, floor shift then add start
    logic [2:0][PW-1:0] sh_c;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            sh_c[i] = PW'($signed(p_b_reg[i]) >>> FRACTION_BITS);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            hit            <= hit_b_reg;
            entry_fraction <= hit_b_reg ? enter_b_reg : '0;
            for (int i = 0; i < 3; i++)
            begin
                hit_pt[i] <= hit_b_reg ? (s_b_reg[i] + sh_c[i][CW-1:0]) : '0;
            end
        end
    end

endmodule

// ===== tb/sbsi_result_checker.sv =====
// checker: predicts the slab test result for each segment transfer and compares outputs
`timescale 1ns / 100ps
module sbsi_result_checker #(
    parameter int FRACTION_BITS = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    sbsi_seg_if               seg,
    sbsi_res_if               res,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [sbsi_pkg::ADDR_W-1:0] paddr,
    input  logic [sbsi_pkg::DATA_W-1:0] pwdata,
    output int                errors,
    output int                pending,
    output int                results_seen,
    output int                hits_seen
);
    localparam longint FRAC_ONE = 64'sd1 <<< FRACTION_BITS;

    typedef struct packed {
        logic                   hit;
        logic [FRACTION_BITS:0] frac;
        logic [31:0]            hx;
        logic [31:0]            hy;
        logic [31:0]            hz;
    } slab_result_t;

    logic signed [31:0] box_lo [3];
    logic signed [31:0] box_hi [3];
    slab_result_t       expected_q [$];

    function automatic longint abs64(longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic longint slab_fraction(longint num, longint den);
        if (den == 0)
            return 0;
        return (abs64(num) <<< FRACTION_BITS) / abs64(den);
    endfunction

    function automatic longint scale_floor(longint p);
        if (p >= 0)
            return p >>> FRACTION_BITS;
        return -((-p + FRAC_ONE - 1) >>> FRACTION_BITS);
    endfunction

    function automatic slab_result_t predict_intersection(logic [31:0] sw [3],
                                                          logic [31:0] ew [3]);
        longint s [3];
        longint e [3];
        longint lo, hi, st, et, d;
        longint enter, leave;
        bit hit;
        slab_result_t r;
        enter = 0;
        leave = FRAC_ONE;
        hit = 1;
        r = '0;
        for (int i = 0; i < 3; i++)
        begin
            s[i] = longint'($signed(sw[i]));
            e[i] = longint'($signed(ew[i]));
        end
        for (int i = 0; i < 3; i++)
        begin
            if (!hit)
                break;
            lo = longint'(box_lo[i]);
            hi = longint'(box_hi[i]);
            st = 0;
            et = FRAC_ONE;
            d = e[i] - s[i];
            if (s[i] < e[i])
            begin
                if (s[i] > hi || e[i] < lo)
                begin
                    hit = 0;
                    break;
                end
                if (s[i] < lo) st = slab_fraction(lo - s[i], d);
                if (e[i] > hi) et = slab_fraction(hi - s[i], d);
            end
            else
            begin
                if (e[i] > hi || s[i] < lo)
                begin
                    hit = 0;
                    break;
                end
                if (s[i] > hi) st = slab_fraction(hi - s[i], d);
                if (e[i] < lo) et = slab_fraction(lo - s[i], d);
            end
            if (st > enter) enter = st;
            if (et < leave) leave = et;
            if (leave < enter) hit = 0;
        end
        if (!hit)
            return r;
        r.hit  = 1'b1;
        r.frac = enter[FRACTION_BITS:0];
        r.hx   = 32'(s[0] + scale_floor((e[0] - s[0]) * enter));
        r.hy   = 32'(s[1] + scale_floor((e[1] - s[1]) * enter));
        r.hz   = 32'(s[2] + scale_floor((e[2] - s[2]) * enter));
        return r;
    endfunction

    assign pending = expected_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        slab_result_t want, got;
        logic [31:0] sw [3];
        logic [31:0] ew [3];
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                box_lo[i] = sbsi_pkg::BOX_MIN_RESET;
                box_hi[i] = sbsi_pkg::BOX_MAX_RESET;
            end
            expected_q.delete();
            errors = 0;
            results_seen = 0;
            hits_seen = 0;
        end
        else
        begin
            if (res.valid && res.ready)
            begin
                got = '{res.hit, res.entry_fraction, res.hit_x, res.hit_y, res.hit_z};
                results_seen++;
                if (got.hit) hits_seen++;
                if (expected_q.size() == 0)
                begin
                    $display("%0t: result transfer with nothing expected: %p", $time, got);
                    errors++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (got !== want)
                    begin
                        $display("%0t: mismatch expected %p actual %p", $time, want, got);
                        errors++;
                    end
                end
            end
            if (seg.valid && seg.ready)
            begin
                sw = '{seg.start_x, seg.start_y, seg.start_z};
                ew = '{seg.end_x, seg.end_y, seg.end_z};
                expected_q = {expected_q, predict_intersection(sw, ew)};
            end
            if (psel && penable && pwrite)
            begin
                case (3'(paddr >> 2))
                    sbsi_pkg::REG_BOX_MIN_X: box_lo[0] = pwdata;
                    sbsi_pkg::REG_BOX_MIN_Y: box_lo[1] = pwdata;
                    sbsi_pkg::REG_BOX_MIN_Z: box_lo[2] = pwdata;
                    sbsi_pkg::REG_BOX_MAX_X: box_hi[0] = pwdata;
                    sbsi_pkg::REG_BOX_MAX_Y: box_hi[1] = pwdata;
                    sbsi_pkg::REG_BOX_MAX_Z: box_hi[2] = pwdata;
                    default: ;
                endcase
            end
        end
    end
endmodule

// ===== tb/segment_box_slab_intersect_unit_tb.sv =====
// testbench top: segment stimulus, box register writes, stalls and verdict
`timescale 1ns / 100ps
module segment_box_slab_intersect_unit_tb;
    localparam int FRACTION_BITS = 16;
    localparam int LATENCY = FRACTION_BITS + 5;
    localparam int RANDOM_ITEMS = 1950;

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [sbsi_pkg::ADDR_W-1:0] paddr;
    logic [sbsi_pkg::DATA_W-1:0] pwdata;
    logic [sbsi_pkg::DATA_W-1:0] prdata;
    logic pready;
    int   errors;
    int   pending;
    int   results_seen;
    int   hits_seen;
    int   segments_sent;
    bit   stall_enable;   // cleared during the stretch without idling

    sbsi_seg_if seg_ch ();
    sbsi_res_if #(.FW(FRACTION_BITS + 1)) res_ch ();

    segment_box_slab_intersect_unit #(.FRACTION_BITS(FRACTION_BITS)) u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .seg_in  (seg_ch),
        .res_out (res_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    sbsi_result_checker #(.FRACTION_BITS(FRACTION_BITS)) u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .seg          (seg_ch),
        .res          (res_ch),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .errors       (errors),
        .pending      (pending),
        .results_seen (results_seen),
        .hits_seen    (hits_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // hard stop well past the slowest correct run
    initial
    begin
        #20ms;
        $display("timeout with %0d results outstanding", pending);
        $display("FAIL");
        $finish;
    end

    // result side: stall with a probability of roughly 12 percent, unless stalls are off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_ch.ready <= 1'b0;
        else
            res_ch.ready <= !stall_enable || ($urandom_range(99) >= 12);
    end

    // one register write: setup cycle, then access cycle
    task automatic write_box_reg(logic [2:0] idx, logic [31:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= sbsi_pkg::ADDR_W'({idx, 2'b00});
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic load_box(logic [31:0] lx, logic [31:0] ly, logic [31:0] lz,
                            logic [31:0] hx, logic [31:0] hy, logic [31:0] hz);
        write_box_reg(sbsi_pkg::REG_BOX_MIN_X, lx);
        write_box_reg(sbsi_pkg::REG_BOX_MIN_Y, ly);
        write_box_reg(sbsi_pkg::REG_BOX_MIN_Z, lz);
        write_box_reg(sbsi_pkg::REG_BOX_MAX_X, hx);
        write_box_reg(sbsi_pkg::REG_BOX_MAX_Y, hy);
        write_box_reg(sbsi_pkg::REG_BOX_MAX_Z, hz);
    endtask

    // drop valid, then drain the pipeline before touching the box registers
    task automatic wait_drained();
        seg_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    // present one segment right after an edge, hold it until the transfer happens
    task automatic send_segment(logic [31:0] sx, logic [31:0] sy, logic [31:0] sz,
                                logic [31:0] ex, logic [31:0] ey, logic [31:0] ez);
        while (stall_enable && $urandom_range(99) < 12)
        begin
            seg_ch.valid <= 1'b0;
            @(posedge clk);
        end
        seg_ch.valid   <= 1'b1;
        seg_ch.start_x <= sx;
        seg_ch.start_y <= sy;
        seg_ch.start_z <= sz;
        seg_ch.end_x   <= ex;
        seg_ch.end_y   <= ey;
        seg_ch.end_z   <= ez;
        do
            @(posedge clk);
        while (!seg_ch.ready);
        // transfer on this edge; valid stays up so the next segment can follow at once
        segments_sent++;
    endtask

    // coordinate near the box scale, sometimes anywhere in the full range
    function automatic logic [31:0] pick_coord(int span);
        case ($urandom_range(9))
            0: return $urandom();
            1: return 32'h8000_0000;
            2: return 32'h7FFF_FFFF;
            default: return 32'($signed($urandom_range(2 * span)) - span);
        endcase
    endfunction

    task automatic random_segments(int count, int span);
        for (int n = 0; n < count; n++)
        begin
            // degenerate axes now and then
            logic [31:0] sx, sy, sz, ex, ey, ez;
            sx = pick_coord(span);
            sy = pick_coord(span);
            sz = pick_coord(span);
            ex = ($urandom_range(15) == 0) ? sx : pick_coord(span);
            ey = ($urandom_range(15) == 0) ? sy : pick_coord(span);
            ez = ($urandom_range(15) == 0) ? sz : pick_coord(span);
            send_segment(sx, sy, sz, ex, ey, ez);
        end
    endtask

    initial
    begin
        stall_enable = 1'b1;
        segments_sent = 0;
        rst_n   = 1'b0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        seg_ch.valid   = 1'b0;
        seg_ch.start_x = '0;
        seg_ch.start_y = '0;
        seg_ch.start_z = '0;
        seg_ch.end_x   = '0;
        seg_ch.end_y   = '0;
        seg_ch.end_z   = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // directed, reset box of +-0.5
        send_segment(32'hFFFF_0000, 0, 0, 32'h0001_0000, 0, 0);           // crosses x
        send_segment(0, 32'h0001_0000, 0, 0, 32'hFFFF_0000, 0);           // falling y
        send_segment(0, 0, 0, 0, 0, 0);                                    // point inside
        send_segment(32'h0001_0000, 0, 0, 32'h0001_0000, 0, 0);           // degenerate outside
        send_segment(32'h0000_8000, 0, 0, 32'h0001_0000, 0, 0);           // touches max face
        send_segment(32'h0001_0000, 0, 0, 32'h0002_0000, 0, 0);           // rising, beyond
        send_segment(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                     32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);          // full diagonal
        send_segment(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                     32'h8000_0000, 32'h8000_0000, 32'h8000_0000);          // reversed
        send_segment(32'hFFFF_0000, 32'h0000_C000, 0,
                     32'h0001_0000, 32'hFFFF_4000, 0);                      // crosses x and falling y
        send_segment(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                     32'h0000_0001, 32'h0000_0001, 32'h0000_0001);
        wait_drained();

        // extreme box, then inverted box
        load_box(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_segment(32'h8000_0000, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 32'h8000_0000);
        send_segment(32'h1234_5678, 32'hFEDC_BA98, 0, 32'h1234_5678, 0, 32'h5555_AAAA);
        wait_drained();
        load_box(32'h0001_0000, 32'h0001_0000, 32'h0001_0000,
                 32'hFFFF_0000, 32'hFFFF_0000, 32'hFFFF_0000);
        send_segment(32'hFFFE_0000, 32'hFFFE_0000, 32'hFFFE_0000,
                     32'h0002_0000, 32'h0002_0000, 32'h0002_0000);
        send_segment(0, 0, 0, 0, 0, 0);
        send_segment(32'h0002_0000, 0, 0, 32'hFFFE_0000, 0, 0);
        wait_drained();

        // random phases over several boxes
        load_box(32'hFFFF_8000, 32'hFFFF_8000, 32'hFFFF_8000,
                 32'h0000_8000, 32'h0000_8000, 32'h0000_8000);
        random_segments(RANDOM_ITEMS / 4, 32'h0002_0000);
        stall_enable = 1'b0;      // no idling on either side for a while
        random_segments(RANDOM_ITEMS / 8, 32'h0002_0000);
        stall_enable = 1'b1;
        wait_drained();
        load_box(32'h8000_0000, 32'hFFF0_0000, 32'h0000_0000,
                 32'h7FFF_FFFF, 32'h0010_0000, 32'h0000_0000);
        random_segments(RANDOM_ITEMS / 8, 32'h0020_0000);
        wait_drained();
        load_box($urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom());
        random_segments(RANDOM_ITEMS / 8, 32'h7FFF_FFFF);
        wait_drained();
        load_box(32'hFFFE_0000, 32'hFFFD_0000, 32'hFFFF_F000,
                 32'h0003_0000, 32'h0001_0000, 32'h0000_1000);
        random_segments(RANDOM_ITEMS * 3 / 8, 32'h0004_0000);
        wait_drained();

        $display("%0d segments sent, %0d results checked, %0d hits, several box settings",
                 segments_sent, results_seen, hits_seen);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
